### src/uart_cfd_pkg.sv
// shared types, constants and keyword tables for the uart command frame decoder
// no dependencies; used by every module of the block by scoped names

package uart_cfd_pkg;

  // default frame capacity in characters
  localparam int FRAME_CAPACITY_DEF = 20;
  localparam int CNT_W_DEF          = $clog2(FRAME_CAPACITY_DEF + 1);

  // framing characters
  localparam logic [7:0] START_BYTE = 8'h2B;  // '+'
  localparam logic [7:0] STOP_BYTE  = 8'h3B;  // ';'

  // keyword storage
  localparam int KEEP_CHARS = 6;
  localparam int NUM_KW     = 8;

  // configuration register indexes
  localparam int          CFG_IDX_W       = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_OPEN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_CLOSE = CFG_IDX_W'(1);

  localparam logic [15:0] SERVO_OPEN_RST  = 16'd18000;
  localparam logic [15:0] SERVO_CLOSE_RST = 16'd19000;

  // command codes
  localparam logic [3:0] CMD_NONE   = 4'd0;
  localparam logic [3:0] CMD_LON    = 4'd1;
  localparam logic [3:0] CMD_LOFF   = 4'd2;
  localparam logic [3:0] CMD_WOPEN  = 4'd3;
  localparam logic [3:0] CMD_WCLOSE = 4'd4;
  localparam logic [3:0] CMD_FON    = 4'd5;
  localparam logic [3:0] CMD_FOFF   = 4'd6;
  localparam logic [3:0] CMD_HON    = 4'd7;
  localparam logic [3:0] CMD_HOFF   = 4'd8;

  // keyword text, in command code order; unused positions are never compared
  localparam logic [7:0] KW_CHAR [NUM_KW][KEEP_CHARS] = '{
    '{"L", "O", "N", 8'h00, 8'h00, 8'h00},
    '{"L", "O", "F", "F",   8'h00, 8'h00},
    '{"W", "O", "P", "E",   "N",   8'h00},
    '{"W", "C", "L", "O",   "S",   "E"  },
    '{"F", "O", "N", 8'h00, 8'h00, 8'h00},
    '{"F", "O", "F", "F",   8'h00, 8'h00},
    '{"H", "O", "N", 8'h00, 8'h00, 8'h00},
    '{"H", "O", "F", "F",   8'h00, 8'h00}
  };

  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd4, 3'd5, 3'd6, 3'd3, 3'd4, 3'd3, 3'd4
  };

  // one result item
  typedef struct packed {
    logic        light_on;
    logic        fan_on;
    logic        heater_on;
    logic [15:0] servo_compare;
    logic        frame_done;
    logic        frame_dropped;
    logic [3:0]  command_code;
  } result_t;

endpackage

### src/ucfd_kw_match.sv
// keyword matcher: compares the stored frame characters against the keyword table
// depends on uart_cfd_pkg

module ucfd_kw_match #(
  parameter int CNT_W = uart_cfd_pkg::CNT_W_DEF
) (
  input  logic [CNT_W-1:0] char_count,
  input  logic [7:0]       kw_chars [uart_cfd_pkg::KEEP_CHARS],
  output logic [3:0]       match_code
);

  logic found;
  logic same;

  always_comb begin
    found      = 1'b0;
    same       = 1'b0;
    match_code = uart_cfd_pkg::CMD_NONE;
    for (int k = 0; k < uart_cfd_pkg::NUM_KW; k++) begin
      same = (char_count == CNT_W'(uart_cfd_pkg::KW_LEN[k]));
      for (int i = 0; i < uart_cfd_pkg::KEEP_CHARS; i++) begin
        // only positions inside this keyword's length count
        if ((3'(i) < uart_cfd_pkg::KW_LEN[k]) &&
            (kw_chars[i] != uart_cfd_pkg::KW_CHAR[k][i])) begin
          same = 1'b0;
        end
      end
      if (same && !found) begin
        found      = 1'b1;
        match_code = 4'(k + 1);
      end
    end
  end

endmodule

### src/ucfd_frame_ctrl.sv
// frame tracking, keyword capture and actuator state for one byte per cycle while fire is high
// depends on uart_cfd_pkg and ucfd_kw_match

module ucfd_frame_ctrl #(
  parameter int FRAME_CAPACITY = uart_cfd_pkg::FRAME_CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            rx_byte,
  input  logic [15:0]           servo_open,
  input  logic [15:0]           servo_close,
  output uart_cfd_pkg::result_t result
);

  localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);

  logic             in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             light_r, light_nxt;
  logic             fan_r, fan_nxt;
  logic             heater_r, heater_nxt;
  logic [15:0]      servo_r, servo_nxt;
  logic [7:0]       kw_chars_r [uart_cfd_pkg::KEEP_CHARS];

  logic       char_wr;
  logic       done;
  logic       dropped;
  logic [3:0] code;
  logic [3:0] match_code;

  ucfd_kw_match #(
    .CNT_W (CNT_W)
  ) u_kw_match (
    .char_count (count_r),
    .kw_chars   (kw_chars_r),
    .match_code (match_code)
  );

  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    light_nxt    = light_r;
    fan_nxt      = fan_r;
    heater_nxt   = heater_r;
    servo_nxt    = servo_r;
    char_wr      = 1'b0;
    done         = 1'b0;
    dropped      = 1'b0;
    code         = uart_cfd_pkg::CMD_NONE;
    if (rx_byte != 8'h00) begin
      if (!in_frame_r) begin
        if (rx_byte == uart_cfd_pkg::START_BYTE) begin
          count_nxt    = '0;
          in_frame_nxt = 1'b1;
        end
      end else if (count_r >= CNT_W'(FRAME_CAPACITY)) begin
        // overlong frame, this byte is swallowed
        in_frame_nxt = 1'b0;
        dropped      = 1'b1;
      end else if (rx_byte == uart_cfd_pkg::STOP_BYTE) begin
        code         = match_code;
        done         = 1'b1;
        in_frame_nxt = 1'b0;
        unique case (match_code)
          uart_cfd_pkg::CMD_LON:    light_nxt  = 1'b1;
          uart_cfd_pkg::CMD_LOFF:   light_nxt  = 1'b0;
          uart_cfd_pkg::CMD_WOPEN:  servo_nxt  = servo_open;
          uart_cfd_pkg::CMD_WCLOSE: servo_nxt  = servo_close;
          uart_cfd_pkg::CMD_FON:    fan_nxt    = 1'b1;
          uart_cfd_pkg::CMD_FOFF:   fan_nxt    = 1'b0;
          uart_cfd_pkg::CMD_HON:    heater_nxt = 1'b1;
          uart_cfd_pkg::CMD_HOFF:   heater_nxt = 1'b0;
          default: ;
        endcase
      end else begin
        char_wr   = 1'b1;
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= '0;
      light_r    <= 1'b0;
      fan_r      <= 1'b0;
      heater_r   <= 1'b0;
      servo_r    <= 16'd0;
    end else if (fire) begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      light_r    <= light_nxt;
      fan_r      <= fan_nxt;
      heater_r   <= heater_nxt;
      servo_r    <= servo_nxt;
    end
  end

  // only the first few characters of a frame are kept
  always_ff @(posedge clk) begin
    for (int i = 0; i < uart_cfd_pkg::KEEP_CHARS; i++) begin
      if (fire && char_wr && (count_r == CNT_W'(i))) begin
        kw_chars_r[i] <= rx_byte;
      end
    end
  end

  always_comb begin
    result.light_on      = light_nxt;
    result.fan_on        = fan_nxt;
    result.heater_on     = heater_nxt;
    result.servo_compare = servo_nxt;
    result.frame_done    = done;
    result.frame_dropped = dropped;
    result.command_code  = code;
  end

endmodule

### src/uart_command_frame_decoder_core.sv
// top level of the uart command frame decoder: input register, config registers,
// frame logic and output register; depends on uart_cfd_pkg and ucfd_frame_ctrl
//
// a byte is held in the input register and its item in the output register on out_*
// throughput: one byte per cycle while out_ready is high; the input and output
// registers let a new byte enter while a finished item waits for out_ready
// reset (rst_n low, synchronous): pipeline empty, idle, actuators off, servo compare 0,
// servo open/close compare registers back to 18000/19000

module uart_command_frame_decoder_core #(
  parameter int FRAME_CAPACITY = uart_cfd_pkg::FRAME_CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // byte input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_rx_byte,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_light_on,
  output logic                               out_fan_on,
  output logic                               out_heater_on,
  output logic [15:0]                        out_servo_compare,
  output logic                               out_frame_done,
  output logic                               out_frame_dropped,
  output logic [3:0]                         out_command_code,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [uart_cfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                        cfg_wdata
);

  // input register stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // output register stage
  logic                  out_valid_r;
  uart_cfd_pkg::result_t out_item_r;

  // config registers
  logic [15:0] servo_open_r;
  logic [15:0] servo_close_r;

  uart_cfd_pkg::result_t result;
  logic                  fire;

  // the held byte is processed when the output slot is free or being emptied
  assign fire     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // config writes land at once; the user must send them only while the block is idle; the block does not check this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_open_r  <= uart_cfd_pkg::SERVO_OPEN_RST;
      servo_close_r <= uart_cfd_pkg::SERVO_CLOSE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        uart_cfd_pkg::REG_SERVO_OPEN:  servo_open_r  <= cfg_wdata;
        uart_cfd_pkg::REG_SERVO_CLOSE: servo_close_r <= cfg_wdata;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  ucfd_frame_ctrl #(
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_frame_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .rx_byte     (s1_byte_r),
    .servo_open  (servo_open_r),
    .servo_close (servo_close_r),
    .result      (result)
  );

  // output register holds the item until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_light_on      = out_item_r.light_on;
  assign out_fan_on        = out_item_r.fan_on;
  assign out_heater_on     = out_item_r.heater_on;
  assign out_servo_compare = out_item_r.servo_compare;
  assign out_frame_done    = out_item_r.frame_done;
  assign out_frame_dropped = out_item_r.frame_dropped;
  assign out_command_code  = out_item_r.command_code;

endmodule
